// ===== sv/mrrp_pkg.sv =====
`timescale 1ns / 1ps

package mrrp_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned KIND_W = 8;

    localparam logic [KIND_W-1:0] KIND_ABS32  = 8'd2;
    localparam logic [KIND_W-1:0] KIND_JUMP26 = 8'd4;
    localparam logic [KIND_W-1:0] KIND_HI16   = 8'd5;
    localparam logic [KIND_W-1:0] KIND_LO16   = 8'd6;

    typedef enum logic [2:0] {
        ST_WRITE       = 3'd0,
        ST_HI_END      = 3'd1,
        ST_HI_UNPAIRED = 3'd2,
        ST_LONE_LO     = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] write_word;
        logic [ADDR_W-1:0] write_address;
        t_status           status;
        logic              last;
    } t_result;

endpackage

// ===== sv/mips_rel_relocation_patcher.sv =====
`timescale 1ns / 1ps

// Patches MIPS REL relocations for a module loaded at the configured base address.
// Each input beat carries one relocation entry and the word currently stored at its
// target. The block accepts one entry per cycle unless its output stalls or a second
// write is pending, and gives its results through an input and an output register.
// A HI16 entry that is not last is held until the next entry and gives no result. A
// paired LO16 gives two beats, the HI16 write then the LO16 write; the second waits
// in a pending register and stalls new entries until it is sent on. Errors give a
// single beat with a nonzero status, zero address and zero data, and drop any held
// HI16. The base address is written through the configuration channel, which is
// always ready, and should only change while no entries are in flight.
module mips_rel_relocation_patcher (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [31:0]            i_cfg_data,          // base_address

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [63:0]            s_axis_tdata,        // patch_offset, original_word
    input  logic [7:0]             s_axis_tuser,        // reloc_kind
    input  logic                   s_axis_tlast,        // section_last

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [63:0]            m_axis_tdata,        // write_address, write_word
    output logic [2:0]             m_axis_tuser,        // status
    output logic                   m_axis_tlast         // last
);
    import mrrp_pkg::*;

    logic [ADDR_W-1:0] r_base;

    logic              r_in_valid;
    logic [KIND_W-1:0] r_in_kind;
    logic [ADDR_W-1:0] r_in_offset;
    logic [WORD_W-1:0] r_in_word;
    logic              r_in_last;

    logic              r_held_valid;
    logic [ADDR_W-1:0] r_held_address;
    logic [WORD_W-1:0] r_held_word;
    logic              n_held_valid;
    logic [ADDR_W-1:0] n_held_address;
    logic [WORD_W-1:0] n_held_word;

    logic              r_out_valid;
    t_result           r_out;
    logic              r_pend_valid;
    t_result           r_pend;

    t_result           n_first;
    t_result           n_second;
    logic              n_first_valid;
    logic              n_second_valid;
    logic              n_error;

    logic              out_free;
    logic              fire;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] lo_sext;
    logic [WORD_W-1:0] newval;
    logic [WORD_W-1:0] newval_rnd;
    logic [WORD_W-1:0] jump_target;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && !r_pend_valid && out_free;
    assign s_axis_tready = !r_in_valid || fire;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.write_word, r_out.write_address};
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;

    assign addr        = r_base + r_in_offset;
    assign lo_sext     = {{16{r_in_word[15]}}, r_in_word[15:0]};
    assign newval      = {r_held_word[15:0], 16'h0000} + lo_sext + r_base;
    assign newval_rnd  = newval + 32'h0000_8000;
    assign jump_target = {4'b0000, r_in_word[25:0], 2'b00} + r_base;

    always_comb begin
        n_first        = '{write_word: '0, write_address: '0, status: ST_WRITE, last: 1'b1};
        n_second       = '{write_word: '0, write_address: '0, status: ST_WRITE, last: 1'b1};
        n_first_valid  = 1'b1;
        n_second_valid = 1'b0;
        n_error        = 1'b0;
        n_held_valid   = r_held_valid;
        n_held_address = r_held_address;
        n_held_word    = r_held_word;
        if (r_held_valid) begin
            n_held_valid   = 1'b0;
            n_held_address = '0;
            n_held_word    = '0;
            if (r_in_kind != KIND_LO16) begin
                n_error        = 1'b1;
                n_first.status = ST_HI_UNPAIRED;
            end else begin
                n_first.write_address  = r_held_address;
                n_first.write_word     = {r_held_word[31:16], newval_rnd[31:16]};
                n_first.last           = 1'b0;
                n_second.write_address = addr;
                n_second.write_word    = {r_in_word[31:16], newval[15:0]};
                n_second_valid         = 1'b1;
            end
        end else begin
            unique case (r_in_kind)
                KIND_ABS32: begin
                    n_first.write_address = addr;
                    n_first.write_word    = r_in_word + r_base;
                end
                KIND_JUMP26: begin
                    n_first.write_address = addr;
                    n_first.write_word    = {r_in_word[31:26], jump_target[27:2]};
                end
                KIND_HI16: begin
                    if (r_in_last) begin
                        n_error        = 1'b1;
                        n_first.status = ST_HI_END;
                    end else begin
                        n_first_valid  = 1'b0;
                        n_held_valid   = 1'b1;
                        n_held_address = addr;
                        n_held_word    = r_in_word;
                    end
                end
                KIND_LO16: begin
                    n_error        = 1'b1;
                    n_first.status = ST_LONE_LO;
                end
                default: begin
                    n_error        = 1'b1;
                    n_first.status = ST_UNSUPPORTED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind   <= s_axis_tuser;
            r_in_offset <= s_axis_tdata[31:0];
            r_in_word   <= s_axis_tdata[63:32];
            r_in_last   <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid   <= 1'b0;
            r_held_address <= '0;
            r_held_word    <= '0;
        end else if (fire) begin
            r_held_valid   <= n_held_valid;
            r_held_address <= n_held_address;
            r_held_word    <= n_held_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (fire) begin
                r_out_valid  <= n_first_valid;
                r_pend_valid <= n_second_valid;
            end else begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (fire) begin
                r_out  <= n_first;
                r_pend <= n_second;
            end
        end
    end

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_out_valid && !r_out.last && r_pend.last))
        else $error("Second write of a pair is pending without its first write.");

    a_error_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_error) |=> !r_held_valid)
        else $error("A held HI16 entry survived an error.");

    a_error_beat_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_WRITE)) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("Error beat carries data or is not marked last.");

    a_hold_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_held_valid && $rose(n_held_valid)) |-> !n_first_valid)
        else $error("A held HI16 entry produced a result.");

    a_stall_on_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !fire)
        else $error("An entry was processed while a second write was pending.");

endmodule
